FILE: hw/rtl/fxa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fxa_pkg
// Shared types and constants of the filtered-x LMS adaptive filter.
// ---------------------------------------------------------------------------
package fxa_pkg;

   // Sample and weight widths, coefficient count and register-port widths
   localparam int SAMPLE_W = 16;
   localparam int WEIGHT_W = 32;
   localparam int NUM_COEF = 4;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   // Saturation limits
   localparam logic signed [SAMPLE_W-1:0] Q15_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] Q15_MIN = 16'sh8000;
   localparam logic signed [WEIGHT_W-1:0] W_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [WEIGHT_W-1:0] W_MIN   = 32'sh8000_0000;

   // Register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_STEP_SIZE     = 3'd0;
   localparam logic [2:0] REG_SEC_TAPS_USED = 3'd1;
   localparam logic [2:0] REG_SEC_COEF_0    = 3'd2;
   localparam logic [2:0] REG_SEC_COEF_1    = 3'd3;
   localparam logic [2:0] REG_SEC_COEF_2    = 3'd4;
   localparam logic [2:0] REG_SEC_COEF_3    = 3'd5;

   // Register reset values
   localparam logic [15:0] STEP_SIZE_RST     = 16'd0;
   localparam logic [2:0]  SEC_TAPS_USED_RST = 3'd1;
   localparam logic signed [SAMPLE_W-1:0] SEC_COEF_0_RST = 16'sh7FFF;

   // Contents of one cell of the tap chain
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] f;
      logic signed [WEIGHT_W-1:0] w;
   } cell_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_ROTATE
   } cell_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEC,
      ST_ROT,
      ST_FIN
   } state_type;

   // Control of the head unit
   typedef struct packed {
      logic clear;
      logic acc_en;
   } head_ctl_type;

endpackage

FILE: hw/rtl/fxa_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fxa_cell
// One tap of the chain: reference, filtered reference and weight. Shifts
// history from the lower neighbor or rotates all fields from the upper one.
// ---------------------------------------------------------------------------
module fxa_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  fxa_pkg::cell_mode_type mode,
   input  fxa_pkg::cell_type     shift_in,
   input  fxa_pkg::cell_type     rot_in,
   output fxa_pkg::cell_type     q
);
   import fxa_pkg::*;

   cell_type cell_ff;
   cell_type cell_in;

   // Select next content by mode
   always_comb begin
      cell_in = cell_ff;
      case (mode)
         CELL_SHIFT: begin
            cell_in.x = shift_in.x;
            cell_in.f = shift_in.f;
         end
         CELL_ROTATE: begin
            cell_in = rot_in;
         end
         default: begin
            cell_in = cell_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign q = cell_ff;

endmodule

FILE: hw/rtl/fxa_sec_filter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fxa_sec_filter
// Secondary-path model: one multiply-accumulate per tap, then round and
// saturate the filtered reference to Q1.15.
// ---------------------------------------------------------------------------
module fxa_sec_filter #(
   parameter int TAPS     = 32,
   parameter int SEC_TAPS = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [fxa_pkg::SAMPLE_W-1:0]   taps      [SEC_TAPS],
   input  logic signed [fxa_pkg::SAMPLE_W-1:0]   coef      [fxa_pkg::NUM_COEF],
   input  logic [2:0]                            taps_used,
   output logic                                  done,
   output logic signed [fxa_pkg::SAMPLE_W-1:0]   filt
);
   import fxa_pkg::*;

   localparam int SCW = $clog2(SEC_TAPS + 1);
   localparam int SIW = (SEC_TAPS > 1) ? $clog2(SEC_TAPS) : 1;
   localparam int PW  = 2 * SAMPLE_W;
   localparam int FAW = PW + $clog2(SEC_TAPS) + 1;

   logic                  busy_ff;
   logic [SCW-1:0]        cnt_ff;
   logic                  pv_ff;
   logic signed [PW-1:0]  prod_ff;
   logic signed [FAW-1:0] facc_ff;

   logic signed [SAMPLE_W-1:0] coef_sel [SEC_TAPS];
   logic                  issue;
   logic                  use_tap;
   logic [SIW-1:0]        tap_idx;
   logic signed [PW-1:0]  prod_in;
   logic signed [FAW:0]   rnd;
   logic signed [FAW-15:0] shifted;

   // Taps past the coefficient registers or past the history count as zero
   for (genvar k = 0; k < SEC_TAPS; k++) begin : g_coef
      if (k < NUM_COEF && k < TAPS) begin : g_used
         assign coef_sel[k] = coef[k];
      end else begin : g_zero
         assign coef_sel[k] = '0;
      end
   end

   // Issue one product per cycle
   always_comb begin
      issue   = busy_ff && (cnt_ff != SCW'(SEC_TAPS));
      tap_idx = cnt_ff[SIW-1:0];
      use_tap = (32'(cnt_ff) < 32'(taps_used));
      prod_in = '0;
      if (issue && use_tap) begin
         prod_in = coef_sel[tap_idx] * taps[tap_idx];
      end
      done = busy_ff && !issue && !pv_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         pv_ff   <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         pv_ff   <= 1'b0;
      end else begin
         pv_ff <= issue;
         if (issue) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (done) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Accumulate products
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (start) begin
         facc_ff <= '0;
      end else if (pv_ff) begin
         facc_ff <= facc_ff + FAW'(prod_ff);
      end
   end

   // Round to Q1.15 and saturate
   always_comb begin
      rnd     = (FAW+1)'(facc_ff) + (FAW+1)'(signed'(33'sd16384));
      shifted = rnd[FAW:15];
      if (shifted > (FAW-14)'(Q15_MAX)) begin
         filt = Q15_MAX;
      end else if (shifted < (FAW-14)'(Q15_MIN)) begin
         filt = Q15_MIN;
      end else begin
         filt = shifted[SAMPLE_W-1:0];
      end
   end

endmodule

FILE: hw/rtl/fxa_head.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fxa_head
// Head of the rotating chain: multiplies the passing tap, accumulates the
// anti-noise sum and writes the updated weight back into the tail.
// ---------------------------------------------------------------------------
module fxa_head #(
   parameter int TAPS = 32
) (
   input  logic                                 clock,
   input  fxa_pkg::head_ctl_type                ctl,
   input  logic [15:0]                          step_size,
   input  logic signed [fxa_pkg::SAMPLE_W-1:0]  err,
   input  fxa_pkg::cell_type                    cell0,
   output fxa_pkg::cell_type                    wb,
   output logic signed [fxa_pkg::SAMPLE_W-1:0]  anti_noise
);
   import fxa_pkg::*;

   localparam int MUW = 33;
   localparam int PUW = MUW + SAMPLE_W;
   localparam int PYW = WEIGHT_W + SAMPLE_W;
   localparam int YW  = PYW + $clog2(TAPS);

   logic signed [MUW-1:0]      mue_ff;
   logic signed [SAMPLE_W-1:0] s_x_ff;
   logic signed [SAMPLE_W-1:0] s_f_ff;
   logic signed [WEIGHT_W-1:0] s_w_ff;
   logic signed [PUW-1:0]      s_pu_ff;
   logic signed [PYW-1:0]      s_py_ff;
   logic signed [YW-1:0]       yacc_ff;

   logic signed [PUW:0]        usum;
   logic signed [PUW-16:0]     delta;
   logic signed [WEIGHT_W+3:0] wsum;
   logic signed [YW:0]         yrnd;
   logic signed [YW-30:0]      yshift;

   // Stage the passing tap and its products
   always_ff @(posedge clock) begin
      mue_ff  <= signed'({1'b0, step_size}) * err;
      s_x_ff  <= cell0.x;
      s_f_ff  <= cell0.f;
      s_w_ff  <= cell0.w;
      s_pu_ff <= mue_ff * cell0.f;
      s_py_ff <= cell0.w * cell0.x;
   end

   // Round the update to Q2.30, add and saturate the weight
   always_comb begin
      usum  = (PUW+1)'(s_pu_ff) + (PUW+1)'(signed'(17'sd32768));
      delta = usum[PUW:16];
      wsum  = (WEIGHT_W+4)'(s_w_ff) + (WEIGHT_W+4)'(delta);
      wb.x  = s_x_ff;
      wb.f  = s_f_ff;
      if (wsum > (WEIGHT_W+4)'(W_MAX)) begin
         wb.w = W_MAX;
      end else if (wsum < (WEIGHT_W+4)'(W_MIN)) begin
         wb.w = W_MIN;
      end else begin
         wb.w = wsum[WEIGHT_W-1:0];
      end
   end

   // Accumulate weight times history
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         yacc_ff <= '0;
      end else if (ctl.acc_en) begin
         yacc_ff <= yacc_ff + YW'(s_py_ff);
      end
   end

   // Round to Q1.15 and saturate
   always_comb begin
      yrnd   = (YW+1)'(yacc_ff) + (YW+1)'(signed'(31'sd536870912));
      yshift = yrnd[YW:30];
      if (yshift > (YW-29)'(Q15_MAX)) begin
         anti_noise = Q15_MAX;
      end else if (yshift < (YW-29)'(Q15_MIN)) begin
         anti_noise = Q15_MIN;
      end else begin
         anti_noise = yshift[SAMPLE_W-1:0];
      end
   end

endmodule

FILE: hw/rtl/fxlms_adaptive_filter_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fxlms_adaptive_filter_unit
// Filtered-x LMS adaptive filter with a rotating chain of tap cells.
// ---------------------------------------------------------------------------
// Usage:
//  - Request channel (req_valid / req_stall) carries one reference sample and
//    one error sample per transaction; response channel (rsp_valid /
//    rsp_stall) returns one anti_noise sample per request.
//  - The APB-style csr port holds step size, secondary tap count and the four
//    secondary-path coefficients; write them while the block is idle.
//  - Per sample: the secondary-path MAC and history shift, then one rotation
//    of the tap chain past the shared head multipliers, then the output is
//    rounded and loaded. A new sample is taken only once the previous one
//    has been written into the output register.
//  - req_stall is high from acceptance until the result is written into the
//    output register. A result waiting under rsp_stall does not block the
//    next request; only the following result waits for it.
//  - Reset clears histories, weights, registers to their reset values and
//    drops any pending response.
// ---------------------------------------------------------------------------
module fxlms_adaptive_filter_unit #(
   parameter int TAPS     = 32,
   parameter int SEC_TAPS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [fxa_pkg::SAMPLE_W-1:0]  req_reference,
   input  logic signed [fxa_pkg::SAMPLE_W-1:0]  req_error_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [fxa_pkg::SAMPLE_W-1:0]  rsp_anti_noise,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fxa_pkg::CSR_AW-1:0]           csr_paddr,
   input  logic [fxa_pkg::CSR_DW-1:0]           csr_pwdata,
   output logic [fxa_pkg::CSR_DW-1:0]           csr_prdata,
   output logic                                 csr_pready
);
   import fxa_pkg::*;

   localparam int RCW = $clog2(TAPS + 1);

   // Configuration registers
   logic [15:0]                step_size_ff;
   logic [2:0]                 sec_taps_used_ff;
   logic signed [SAMPLE_W-1:0] sec_coef_ff [NUM_COEF];
   logic                       csr_wr;
   logic [2:0]                 csr_idx;

   // Control
   state_type                  state_ff;
   state_type                  state_in;
   logic [RCW-1:0]             rot_cnt_ff;
   logic [RCW-1:0]             rot_cnt_in;
   logic                       accept;
   logic                       out_load;
   cell_mode_type              cell_mode;
   head_ctl_type               head_ctl;

   // Sample holding and output
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [SAMPLE_W-1:0] e_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_anti_noise_ff;

   // Datapath
   cell_type                   cell_q   [TAPS];
   cell_type                   cell_sh  [TAPS];
   cell_type                   cell_rot [TAPS];
   cell_type                   wb;
   logic signed [SAMPLE_W-1:0] sec_taps [SEC_TAPS];
   logic                       sec_done;
   logic signed [SAMPLE_W-1:0] filt;
   logic signed [SAMPLE_W-1:0] y_sum;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff     <= STEP_SIZE_RST;
         sec_taps_used_ff <= SEC_TAPS_USED_RST;
         sec_coef_ff[0]   <= SEC_COEF_0_RST;
         sec_coef_ff[1]   <= '0;
         sec_coef_ff[2]   <= '0;
         sec_coef_ff[3]   <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_STEP_SIZE:     step_size_ff     <= csr_pwdata[15:0];
            REG_SEC_TAPS_USED: sec_taps_used_ff <= csr_pwdata[2:0];
            REG_SEC_COEF_0:    sec_coef_ff[0]   <= csr_pwdata[15:0];
            REG_SEC_COEF_1:    sec_coef_ff[1]   <= csr_pwdata[15:0];
            REG_SEC_COEF_2:    sec_coef_ff[2]   <= csr_pwdata[15:0];
            REG_SEC_COEF_3:    sec_coef_ff[3]   <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Read back register values
   always_comb begin
      case (csr_idx)
         REG_STEP_SIZE:     csr_prdata = CSR_DW'(step_size_ff);
         REG_SEC_TAPS_USED: csr_prdata = CSR_DW'(sec_taps_used_ff);
         REG_SEC_COEF_0:    csr_prdata = CSR_DW'(unsigned'(sec_coef_ff[0]));
         REG_SEC_COEF_1:    csr_prdata = CSR_DW'(unsigned'(sec_coef_ff[1]));
         REG_SEC_COEF_2:    csr_prdata = CSR_DW'(unsigned'(sec_coef_ff[2]));
         REG_SEC_COEF_3:    csr_prdata = CSR_DW'(unsigned'(sec_coef_ff[3]));
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------- sequencer ----------------
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in        = state_ff;
      rot_cnt_in      = rot_cnt_ff;
      cell_mode       = CELL_HOLD;
      head_ctl.clear  = accept;
      head_ctl.acc_en = 1'b0;
      out_load        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SEC;
            end
         end
         ST_SEC: begin
            // Shift new sample and filtered reference into the chain
            if (sec_done) begin
               cell_mode  = CELL_SHIFT;
               rot_cnt_in = '0;
               state_in   = ST_ROT;
            end
         end
         ST_ROT: begin
            // Rotate every tap once past the head
            cell_mode       = CELL_ROTATE;
            head_ctl.acc_en = (rot_cnt_ff != '0);
            rot_cnt_in      = rot_cnt_ff + 1'b1;
            if (rot_cnt_ff == RCW'(TAPS)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Hold while the previous result is still waiting
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rot_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         rot_cnt_ff <= rot_cnt_in;
      end
   end

   // Capture the input samples
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff <= req_reference;
         e_ff <= req_error_sample;
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_anti_noise_ff <= y_sum;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_anti_noise = rsp_anti_noise_ff;

   // ---------------- secondary-path filter ----------------
   // Newest history: the held sample, then the chain before its shift
   for (genvar k = 0; k < SEC_TAPS; k++) begin : g_sec_tap
      if (k == 0) begin : g_new
         assign sec_taps[k] = x_ff;
      end else if (k - 1 < TAPS) begin : g_hist
         assign sec_taps[k] = cell_q[k-1].x;
      end else begin : g_none
         assign sec_taps[k] = '0;
      end
   end

   fxa_sec_filter #(
      .TAPS     (TAPS),
      .SEC_TAPS (SEC_TAPS)
   ) u_sec (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .taps      (sec_taps),
      .coef      (sec_coef_ff),
      .taps_used (sec_taps_used_ff),
      .done      (sec_done),
      .filt      (filt)
   );

   // ---------------- tap chain ----------------
   for (genvar i = 0; i < TAPS; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign cell_sh[i] = '{x: x_ff, f: filt, w: '0};
      end else begin : g_shift
         assign cell_sh[i] = cell_q[i-1];
      end
      if (i == TAPS - 1) begin : g_last
         assign cell_rot[i] = wb;
      end else begin : g_rot
         assign cell_rot[i] = cell_q[i+1];
      end

      fxa_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .mode     (cell_mode),
         .shift_in (cell_sh[i]),
         .rot_in   (cell_rot[i]),
         .q        (cell_q[i])
      );
   end

   fxa_head #(
      .TAPS (TAPS)
   ) u_head (
      .clock      (clock),
      .ctl        (head_ctl),
      .step_size  (step_size_ff),
      .err        (e_ff),
      .cell0      (cell_q[0]),
      .wb         (wb),
      .anti_noise (y_sum)
   );

endmodule

FILE: tb/fxlms_adaptive_filter_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fxlms_adaptive_filter_unit_tb
// Self-checking bench for the filtered-x LMS filter. A directed table drives
// sample extremes and the register corner cases: secondary tap count zero,
// a tap count above the tap budget, writes to an unmapped register and
// register values with junk in the upper bits. Random phases follow, each
// with its own register setting. A bit-accurate model of the histories and
// weights predicts every anti_noise sample, and both channels idle at random.
// ---------------------------------------------------------------------------
module fxlms_adaptive_filter_unit_tb;
   import fxa_pkg::*;

   localparam int TAPS           = 32;
   localparam int SEC_TAPS       = 4;
   localparam int ITEM_CYCLES    = TAPS + SEC_TAPS + 5;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASES         = 6;
   localparam int PHASE_SAMPLES  = 280;
   localparam logic [2:0] REG_UNMAPPED = 3'd6;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [2:0]                 idx;
      logic [31:0]                wdata;
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] e;
      logic                       known;
      logic signed [SAMPLE_W-1:0] y;
   } stim_row_type;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_reference    = '0;
   logic signed [SAMPLE_W-1:0] req_error_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall        = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_anti_noise;
   logic                       csr_psel         = 1'b0;
   logic                       csr_penable      = 1'b0;
   logic                       csr_pwrite       = 1'b0;
   logic [CSR_AW-1:0]          csr_paddr        = '0;
   logic [CSR_DW-1:0]          csr_pwdata       = '0;
   logic [CSR_DW-1:0]          csr_prdata;
   logic                       csr_pready;

   // Model copy of the registers
   logic [15:0]                mu_model       = STEP_SIZE_RST;
   logic [2:0]                 sec_taps_model = SEC_TAPS_USED_RST;
   logic signed [SAMPLE_W-1:0] sec_coef_model [NUM_COEF] = '{SEC_COEF_0_RST, 0, 0, 0};

   // Model copy of the histories and weights
   logic signed [SAMPLE_W-1:0] x_line  [TAPS] = '{default: '0};
   logic signed [SAMPLE_W-1:0] xf_line [TAPS] = '{default: '0};
   logic signed [WEIGHT_W-1:0] w_line  [TAPS] = '{default: '0};

   logic signed [SAMPLE_W-1:0] anti_noise_q [$];
   stim_row_type               directed_rows [$];
   logic signed [SAMPLE_W-1:0] want;
   int                         mismatch_count = 0;
   int                         idle_pct       = 0;
   int                         stall_hold     = 0;
   int                         quiet_cycles   = 0;

   fxlms_adaptive_filter_unit #(
      .TAPS     (TAPS),
      .SEC_TAPS (SEC_TAPS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_reference    (req_reference),
      .req_error_sample (req_error_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_anti_noise   (rsp_anti_noise),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #5 clock = ~clock;

   task automatic flag_mismatch(string msg);
      $display("%0t ns: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] sat_q15(longint v);
      if (v > longint'(Q15_MAX)) return Q15_MAX;
      if (v < longint'(Q15_MIN)) return Q15_MIN;
      return SAMPLE_W'(v);
   endfunction

   function automatic logic signed [WEIGHT_W-1:0] sat_q31(longint v);
      if (v > longint'(W_MAX)) return W_MAX;
      if (v < longint'(W_MIN)) return W_MIN;
      return WEIGHT_W'(v);
   endfunction

   // Mirror a register write; keep only the register's width, drop unmapped indexes
   function automatic void apply_csr(logic [2:0] idx, logic [31:0] data);
      case (idx)
         REG_STEP_SIZE:     mu_model          = data[15:0];
         REG_SEC_TAPS_USED: sec_taps_model    = data[2:0];
         REG_SEC_COEF_0:    sec_coef_model[0] = data[15:0];
         REG_SEC_COEF_1:    sec_coef_model[1] = data[15:0];
         REG_SEC_COEF_2:    sec_coef_model[2] = data[15:0];
         REG_SEC_COEF_3:    sec_coef_model[3] = data[15:0];
         default: ;
      endcase
   endfunction

   // Advance the model by one sample pair and return the anti_noise output
   function automatic logic signed [SAMPLE_W-1:0] predict_anti_noise(
      logic signed [SAMPLE_W-1:0] x, logic signed [SAMPLE_W-1:0] e);
      longint acc;
      longint mue;
      longint d;
      int     n;
      logic signed [SAMPLE_W-1:0] y;
      for (int i = TAPS - 1; i > 0; i--) x_line[i] = x_line[i-1];
      x_line[0] = x;

      // secondary-path model; taps beyond the coefficient set count as zero
      n = (sec_taps_model > SEC_TAPS) ? SEC_TAPS : int'(sec_taps_model);
      acc = 0;
      for (int i = 0; i < n; i++) begin
         if (i < NUM_COEF) acc += longint'(sec_coef_model[i]) * longint'(x_line[i]);
      end
      for (int i = TAPS - 1; i > 0; i--) xf_line[i] = xf_line[i-1];
      xf_line[0] = sat_q15((acc + 64'sd16384) >>> 15);

      // output uses the weights from before this sample
      acc = 0;
      for (int i = 0; i < TAPS; i++) acc += longint'(w_line[i]) * longint'(x_line[i]);
      y = sat_q15((acc + 64'sd536870912) >>> 30);

      mue = longint'(mu_model) * longint'(e);
      for (int i = 0; i < TAPS; i++) begin
         d = (mue * longint'(xf_line[i]) + 64'sd32768) >>> 16;
         w_line[i] = sat_q31(longint'(w_line[i]) + d);
      end
      return y;
   endfunction

   function automatic int idle_len();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       return Q15_MIN;
               1:       return Q15_MAX;
               2:       return '0;
               default: return -16'sd1;
            endcase
         end
         1:       return SAMPLE_W'($urandom_range(0, 511)) - 16'sd256;
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   function automatic void add_write(logic [2:0] idx, logic [31:0] data);
      directed_rows.push_back('{ROW_CSR, idx, data, 16'sd0, 16'sd0, 1'b0, 16'sd0});
   endfunction

   function automatic void add_sample(logic signed [SAMPLE_W-1:0] x,
                                      logic signed [SAMPLE_W-1:0] e);
      directed_rows.push_back('{ROW_SAMPLE, 3'd0, 32'd0, x, e, 1'b0, 16'sd0});
   endfunction

   function automatic void add_known(logic signed [SAMPLE_W-1:0] x,
                                     logic signed [SAMPLE_W-1:0] e,
                                     logic signed [SAMPLE_W-1:0] y);
      directed_rows.push_back('{ROW_SAMPLE, 3'd0, 32'd0, x, e, 1'b1, y});
   endfunction

   // Present one sample pair after a random gap; return on the accepting edge
   task automatic send_sample(logic signed [SAMPLE_W-1:0] x, logic signed [SAMPLE_W-1:0] e,
                              logic known, logic signed [SAMPLE_W-1:0] known_y);
      logic signed [SAMPLE_W-1:0] y;
      int gap;
      gap = ($urandom_range(0, 99) < idle_pct) ? idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_reference    <= x;
      req_error_sample <= e;
      do @(posedge clock); while (req_stall);
      y = predict_anti_noise(x, e);
      anti_noise_q.push_back(known ? known_y : y);
   endtask

   // Write one register once the filter has drained
   task automatic write_csr(logic [2:0] idx, logic [31:0] data);
      req_valid <= 1'b0;
      while (anti_noise_q.size() != 0 || req_stall) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      apply_csr(idx, data);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Check each response transaction and stall the response side at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (anti_noise_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected anti_noise %0d", rsp_anti_noise));
         end else begin
            want = anti_noise_q.pop_front();
            if (rsp_anti_noise !== want)
               flag_mismatch($sformatf("anti_noise got %0d expected %0d",
                                       rsp_anti_noise, want));
         end
      end
      if (stall_hold > 0) begin
         stall_hold--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         stall_hold = idle_len() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // End the run when no transaction has moved for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("fxlms_adaptive_filter_unit_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [31:0]  mu_w;
      logic [31:0]  taps_w;
      logic [31:0]  coef_w;
      stim_row_type row;

      // With the reset step size of zero the weights stay zero, so the output is zero
      add_known(Q15_MAX, Q15_MAX, 16'sd0);
      add_known(Q15_MIN, Q15_MIN, 16'sd0);
      add_known(16'sd0, 16'sd0, 16'sd0);
      add_known(-16'sd1, 16'sd1, 16'sd0);
      add_known(16'sd1, -16'sd1, 16'sd0);
      // full step, all four taps at the extremes, junk in the upper bits
      add_write(REG_STEP_SIZE, 32'hFFFF_FFFF);
      add_write(REG_SEC_TAPS_USED, 32'hFFFF_FFFC);
      add_write(REG_SEC_COEF_0, 32'h0000_7FFF);
      add_write(REG_SEC_COEF_1, 32'hABCD_8000);
      add_write(REG_SEC_COEF_2, 32'h0000_7FFF);
      add_write(REG_SEC_COEF_3, 32'hFFFF_8000);
      add_write(REG_UNMAPPED, 32'h1234_5678);
      add_sample(Q15_MAX, Q15_MAX);
      add_sample(Q15_MAX, Q15_MAX);
      add_sample(Q15_MAX, Q15_MAX);
      add_sample(Q15_MIN, Q15_MAX);
      add_sample(Q15_MIN, Q15_MAX);
      add_sample(Q15_MAX, Q15_MIN);
      add_sample(Q15_MAX, Q15_MIN);
      add_sample(16'sd0, 16'sd0);
      // tap count above the tap budget
      add_write(REG_SEC_TAPS_USED, 32'd7);
      add_sample(16'sd12345, Q15_MIN);
      add_sample(Q15_MIN, Q15_MAX);
      add_sample(Q15_MAX, 16'sd0);
      // no secondary taps: filtered reference is zero
      add_write(REG_SEC_TAPS_USED, 32'd0);
      add_sample(Q15_MAX, Q15_MAX);
      add_sample(Q15_MIN, Q15_MIN);
      add_sample(-16'sd1, -16'sd1);
      // smallest nonzero step, one negative tap
      add_write(REG_SEC_TAPS_USED, 32'd1);
      add_write(REG_STEP_SIZE, 32'd1);
      add_write(REG_SEC_COEF_0, 32'h0000_8000);
      add_sample(16'sd1000, -16'sd2000);
      add_sample(-16'sd3000, 16'sd4000);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      idle_pct = 25;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) write_csr(row.idx, row.wdata);
         else send_sample(row.x, row.e, row.known, row.y);
      end

      // Random phases, each under its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               mu_w   = 32'h0000_FFFF;
               taps_w = 32'd7;
            end
            1: begin
               mu_w   = 32'd0;
               taps_w = 32'd0;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0:       mu_w = $urandom_range(1, 64);
                  1:       mu_w = $urandom_range(256, 4096);
                  2:       mu_w = 32'h0000_FFFF;
                  default: mu_w = $urandom_range(0, 65535);
               endcase
               taps_w = $urandom_range(0, 7);
            end
         endcase
         write_csr(REG_STEP_SIZE, ($urandom() & 32'hFFFF_0000) | mu_w);
         write_csr(REG_SEC_TAPS_USED, ($urandom() & 32'hFFFF_FFF8) | taps_w);
         for (int c = 0; c < NUM_COEF; c++) begin
            coef_w = (ph == 0) ? 32'h0000_8000 : {16'h0000, pick_sample()};
            write_csr(REG_SEC_COEF_0 + 3'(c), ($urandom() & 32'hFFFF_0000) | coef_w);
         end
         if ($urandom_range(0, 1) == 1) write_csr(3'($urandom_range(6, 7)), $urandom());

         idle_pct = (ph % 3 == 0) ? 0 : $urandom_range(15, 50);
         repeat (PHASE_SAMPLES) send_sample(pick_sample(), pick_sample(), 1'b0, '0);
      end

      // Drain, then give late or extra responses a chance to show
      req_valid <= 1'b0;
      while (anti_noise_q.size() != 0) @(posedge clock);
      repeat (ITEM_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("fxlms_adaptive_filter_unit_tb: done, clean");
      end else begin
         $display("fxlms_adaptive_filter_unit_tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/fxa_pkg.sv
hw/rtl/fxa_cell.sv
hw/rtl/fxa_sec_filter.sv
hw/rtl/fxa_head.sv
hw/rtl/fxlms_adaptive_filter_unit.sv
tb/fxlms_adaptive_filter_unit_tb.sv
